[hw/rtl/cls_pkg.sv]
// Shared types, codes and helpers for the command link supervisor.
// No dependencies; imported by command_link_supervisor, cls_result_checker and the testbench.
`default_nettype none
package cls_pkg;

    localparam int unsigned LINE_MAX_DEF  = 95;
    localparam int unsigned TOKEN_MAX_DEF = 15;

    localparam logic [15:0] CMD_TIMEOUT_RST = 16'd10000;
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd500;
    localparam logic [3:0]  MAX_RETRY_RST   = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2,
        ST_ERR  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REQ_RX   = 2'd0,
        REQ_TICK = 2'd1,
        REQ_CMD  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SEND   = 2'd1,
        EV_RESEND = 2'd2,
        EV_STOP   = 2'd3
    } event_t;

    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_LONG     = 3'd1;
    localparam logic [2:0] CAUSE_CMD_TO   = 3'd2;
    localparam logic [2:0] CAUSE_ACK_TO   = 3'd3;
    localparam logic [2:0] CAUSE_BUSY     = 3'd4;
    localparam logic [2:0] CAUSE_SLAVE    = 3'd5;

    localparam logic [1:0] REG_CMD_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_MAX_RETRY   = 2'd2;

    localparam int unsigned NUM_TYPES = 5;

    // length of message type name i: ACK STATE DONE ERR FAULT
    function automatic logic [7:0] type_len(input int unsigned i);
        logic [7:0] ln;
        case (i)
            0: ln = 8'd3;
            1: ln = 8'd5;
            2: ln = 8'd4;
            3: ln = 8'd3;
            default: ln = 8'd5;
        endcase
        return ln;
    endfunction

    // true when byte c is character p of type name i
    function automatic logic type_char_ok(input int unsigned i, input logic [7:0] p,
                                          input logic [7:0] c);
        logic [39:0] nm;
        logic [7:0]  ln;
        logic        ok;
        case (i)
            0: nm = "ACK";
            1: nm = "STATE";
            2: nm = "DONE";
            3: nm = "ERR";
            default: nm = "FAULT";
        endcase
        ln = type_len(i);
        ok = 1'b0;
        if (p < ln) begin
            ok = (nm[8*(int'(ln) - 1 - int'(p)) +: 8] == c);
        end
        return ok;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/cls_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cls_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/command_link_supervisor.sv]
// Command link supervisor: command load, link line parser, timeouts and resends.
// Each result beat is registered from its accepted input beat; one beat per cycle sustained while m_tready is high.
// Token text is held in a two-bank RAM; banks swap at command start, and the
// read port is addressed in the cycle before the byte is used, with write forwarding.
// Synchronous active-low reset returns to idle with sequence 1; no clearing pass.
// Depends on cls_pkg and cls_ram.
`default_nettype none
module command_link_supervisor
    import cls_pkg::*;
#(
    parameter int unsigned LINE_MAX  = LINE_MAX_DEF,
    parameter int unsigned TOKEN_MAX = TOKEN_MAX_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic [1:0]  s_tuser,   // req_type
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // task_status[1:0] send_event[3:2] event_sequence[35:4] error_cause[38:36]
    // link_online[39] ack_seen[40], zero above
    output logic      [47:0] m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    localparam int unsigned TW   = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
    localparam int unsigned LENW = $clog2(TOKEN_MAX + 1);
    localparam int unsigned LW   = $clog2(LINE_MAX + 1);
    localparam int unsigned AW   = TW + 1;
    localparam logic [LENW-1:0] TOK_MAX = LENW'(TOKEN_MAX);
    localparam logic [LW-1:0]   LIN_MAX = LW'(LINE_MAX);

    // configuration
    logic [15:0] cmd_to_reg, ack_to_reg;
    logic [3:0]  max_retry_reg;

    // control state
    status_t          status_reg, status_next;
    logic [31:0]      next_seq_reg, next_seq_next;
    logic [31:0]      active_seq_reg, active_seq_next;
    logic [3:0]       retry_reg, retry_next;
    logic             ack_reg, ack_next;
    logic [15:0]      since_start_reg, since_start_next;
    logic [15:0]      since_tx_reg, since_tx_next;
    logic             exp_bank_reg, exp_bank_next;
    logic [LENW-1:0]  exp_len_reg, exp_len_next;
    logic [LENW-1:0]  pend_len_reg, pend_len_next;
    logic             pend_comma_reg, pend_comma_next;
    logic [LW-1:0]    line_len_reg, line_len_next;
    logic [1:0]       field_num_reg, field_num_next;
    logic [7:0]       field_pos_reg, field_pos_next;
    logic             in_field_reg, in_field_next;
    logic [4:0]       cand_reg, cand_next;
    logic [31:0]      pseq_reg, pseq_next;
    logic             digits_ok_reg, digits_ok_next;
    logic             tok_match_reg, tok_match_next;
    logic             online_reg, online_next;

    // output stage
    logic             m_valid_reg;
    logic [47:0]      m_data_reg;

    // token RAM
    logic             tok_we;
    logic [AW-1:0]    tok_waddr, tok_raddr, rd_addr_reg, wr_addr_reg;
    logic [7:0]       tok_rdata, wr_data_reg, tok_byte;
    logic             wr_en_reg;
    logic [7:0]       p_eff;

    logic             accept;
    req_t             req;
    logic [7:0]       c;
    event_t           ev;
    logic [31:0]      seq;
    logic [2:0]       cause;
    logic [35:0]      mul10;
    logic             active, cmd_ok;
    logic [7:0]       p;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign req      = req_t'(s_tuser);
    assign c        = s_tdata;

    cls_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_tok_ram (
        .aclk  (aclk),
        .we    (tok_we),
        .waddr (tok_waddr),
        .wdata (c),
        .raddr (tok_raddr),
        .rdata (tok_rdata)
    );

    // a write in the same cycle as the read of that entry is forwarded
    assign tok_byte = (wr_en_reg && wr_addr_reg == rd_addr_reg) ? wr_data_reg : tok_rdata;

    always_comb begin
        status_next     = status_reg;
        next_seq_next   = next_seq_reg;
        active_seq_next = active_seq_reg;
        retry_next      = retry_reg;
        ack_next        = ack_reg;
        since_start_next = since_start_reg;
        since_tx_next   = since_tx_reg;
        exp_bank_next   = exp_bank_reg;
        exp_len_next    = exp_len_reg;
        pend_len_next   = pend_len_reg;
        pend_comma_next = pend_comma_reg;
        line_len_next   = line_len_reg;
        field_num_next  = field_num_reg;
        field_pos_next  = field_pos_reg;
        in_field_next   = in_field_reg;
        cand_next       = cand_reg;
        pseq_next       = pseq_reg;
        digits_ok_next  = digits_ok_reg;
        tok_match_next  = tok_match_reg;
        online_next     = online_reg;
        ev              = EV_NONE;
        seq             = 32'd0;
        cause           = CAUSE_NONE;
        tok_we          = 1'b0;
        tok_waddr       = {!exp_bank_reg, pend_len_reg[TW-1:0]};
        mul10           = 36'd0;
        active          = 1'b0;
        cmd_ok          = 1'b0;
        p               = 8'd0;

        if (accept) begin
            case (req)
                REQ_RX: begin
                    if (c == 8'h0D || c == 8'h0A) begin
                        if (line_len_reg != '0) begin
                            // close open field
                            if (in_field_next) begin
                                if (field_num_next == 2'd0) begin
                                    for (int i = 0; i < NUM_TYPES; i++) begin
                                        if (type_len(i) != field_pos_next)
                                            cand_next[i] = 1'b0;
                                    end
                                end else if (field_num_next == 2'd2) begin
                                    if (field_pos_next != 8'(exp_len_reg))
                                        tok_match_next = 1'b0;
                                end
                                if (field_num_next != 2'd3)
                                    field_num_next = field_num_next + 2'd1;
                            end
                            online_next = 1'b1;
                            if (field_num_next >= 2'd2) begin
                                active = status_reg == ST_RUN && digits_ok_next &&
                                         pseq_next == active_seq_reg;
                                cmd_ok = field_num_next == 2'd3 && tok_match_next;
                                if (cand_next[1:0] != '0 && active) begin
                                    ack_next = 1'b1;
                                end else if (cand_next[2] && active && cmd_ok) begin
                                    ack_next    = 1'b1;
                                    status_next = ST_DONE;
                                end else if (cand_next[4:3] != '0 && active) begin
                                    ack_next    = 1'b1;
                                    status_next = ST_ERR;
                                    cause       = CAUSE_SLAVE;
                                end
                            end
                            line_len_next  = '0;
                            field_num_next = 2'd0;
                            field_pos_next = 8'd0;
                            in_field_next  = 1'b0;
                            cand_next      = 5'h1F;
                            pseq_next      = 32'd0;
                            digits_ok_next = 1'b1;
                            tok_match_next = 1'b0;
                        end
                    end else if (c >= 8'd32 && c <= 8'd126 && line_len_reg < LIN_MAX) begin
                        line_len_next = line_len_reg + LW'(1);
                        if (c == ",") begin
                            if (in_field_reg) begin
                                if (field_num_reg == 2'd0) begin
                                    for (int i = 0; i < NUM_TYPES; i++) begin
                                        if (type_len(i) != field_pos_reg)
                                            cand_next[i] = 1'b0;
                                    end
                                end else if (field_num_reg == 2'd2) begin
                                    if (field_pos_reg != 8'(exp_len_reg))
                                        tok_match_next = 1'b0;
                                end
                                if (field_num_reg != 2'd3)
                                    field_num_next = field_num_reg + 2'd1;
                                in_field_next = 1'b0;
                            end
                        end else begin
                            p = in_field_reg ? field_pos_reg : 8'd0;
                            if (!in_field_reg) begin
                                in_field_next = 1'b1;
                                if (field_num_reg == 2'd1) begin
                                    pseq_next      = 32'd0;
                                    digits_ok_next = 1'b1;
                                end
                                if (field_num_reg == 2'd2) tok_match_next = 1'b1;
                            end
                            if (field_num_reg == 2'd0) begin
                                for (int i = 0; i < NUM_TYPES; i++) begin
                                    if (!type_char_ok(i, p, c)) cand_next[i] = 1'b0;
                                end
                            end else if (field_num_reg == 2'd1) begin
                                if (c >= "0" && c <= "9") begin
                                    mul10 = {pseq_next, 3'b000} + {3'b000, pseq_next, 1'b0}
                                            + {28'd0, c - 8'h30};
                                    pseq_next = (mul10[35:32] != '0) ? 32'hFFFF_FFFF
                                                                     : mul10[31:0];
                                end else begin
                                    digits_ok_next = 1'b0;
                                end
                            end else if (field_num_reg == 2'd2) begin
                                if (p >= 8'(exp_len_reg) || p >= 8'(TOKEN_MAX) ||
                                    tok_byte != c)
                                    tok_match_next = 1'b0;
                            end
                            field_pos_next = (p != 8'hFF) ? p + 8'd1 : p;
                        end
                    end else if (line_len_reg >= LIN_MAX) begin
                        line_len_next  = '0;
                        field_num_next = 2'd0;
                        field_pos_next = 8'd0;
                        in_field_next  = 1'b0;
                        cand_next      = 5'h1F;
                        pseq_next      = 32'd0;
                        digits_ok_next = 1'b1;
                        tok_match_next = 1'b0;
                        status_next    = ST_ERR;
                        cause          = CAUSE_LONG;
                    end
                end
                REQ_TICK: begin
                    if (status_reg == ST_RUN) begin
                        if (since_start_reg != 16'hFFFF)
                            since_start_next = since_start_reg + 16'd1;
                        if (since_tx_reg != 16'hFFFF)
                            since_tx_next = since_tx_reg + 16'd1;
                        if (since_start_next >= cmd_to_reg) begin
                            status_next   = ST_ERR;
                            cause         = CAUSE_CMD_TO;
                            ev            = EV_STOP;
                            seq           = next_seq_reg;
                            next_seq_next = (next_seq_reg == 32'hFFFF_FFFF) ? 32'd1
                                                                            : next_seq_reg + 32'd1;
                        end else if (!ack_reg && since_tx_next >= ack_to_reg) begin
                            if (retry_reg >= max_retry_reg) begin
                                status_next = ST_ERR;
                                cause       = CAUSE_ACK_TO;
                            end else begin
                                retry_next    = retry_reg + 4'd1;
                                since_tx_next = 16'd0;
                                ev            = EV_RESEND;
                                seq           = active_seq_reg;
                            end
                        end
                    end
                end
                REQ_CMD: begin
                    if (c == "," || c == 8'd0) begin
                        pend_comma_next = 1'b1;
                    end else if (!pend_comma_reg && pend_len_reg < TOK_MAX) begin
                        tok_we        = 1'b1;
                        pend_len_next = pend_len_reg + LENW'(1);
                    end
                    if (s_tlast) begin
                        if (status_reg == ST_RUN) begin
                            cause = CAUSE_BUSY;
                        end else begin
                            status_next      = ST_RUN;
                            since_start_next = 16'd0;
                            since_tx_next    = 16'd0;
                            active_seq_next  = next_seq_reg;
                            next_seq_next    = (next_seq_reg == 32'hFFFF_FFFF) ? 32'd1
                                                                               : next_seq_reg + 32'd1;
                            retry_next       = 4'd0;
                            ack_next         = 1'b0;
                            exp_bank_next    = !exp_bank_reg;
                            exp_len_next     = pend_len_next;
                            ev               = EV_SEND;
                            seq              = next_seq_reg;
                        end
                        pend_len_next   = '0;
                        pend_comma_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        // fetch the token byte for the next line character
        p_eff     = in_field_next ? field_pos_next : 8'd0;
        tok_raddr = {exp_bank_next, p_eff[TW-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_to_reg     <= CMD_TIMEOUT_RST;
            ack_to_reg     <= ACK_TIMEOUT_RST;
            max_retry_reg  <= MAX_RETRY_RST;
            status_reg     <= ST_IDLE;
            next_seq_reg   <= 32'd1;
            active_seq_reg <= 32'd0;
            retry_reg      <= 4'd0;
            ack_reg        <= 1'b0;
            since_start_reg <= 16'd0;
            since_tx_reg   <= 16'd0;
            exp_bank_reg   <= 1'b0;
            exp_len_reg    <= '0;
            pend_len_reg   <= '0;
            pend_comma_reg <= 1'b0;
            line_len_reg   <= '0;
            field_num_reg  <= 2'd0;
            field_pos_reg  <= 8'd0;
            in_field_reg   <= 1'b0;
            cand_reg       <= 5'h1F;
            pseq_reg       <= 32'd0;
            digits_ok_reg  <= 1'b1;
            tok_match_reg  <= 1'b0;
            online_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            wr_en_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_CMD_TIMEOUT: cmd_to_reg    <= cfg_wdata;
                    REG_ACK_TIMEOUT: ack_to_reg    <= cfg_wdata;
                    REG_MAX_RETRY:   max_retry_reg <= cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end
            status_reg     <= status_next;
            next_seq_reg   <= next_seq_next;
            active_seq_reg <= active_seq_next;
            retry_reg      <= retry_next;
            ack_reg        <= ack_next;
            since_start_reg <= since_start_next;
            since_tx_reg   <= since_tx_next;
            exp_bank_reg   <= exp_bank_next;
            exp_len_reg    <= exp_len_next;
            pend_len_reg   <= pend_len_next;
            pend_comma_reg <= pend_comma_next;
            line_len_reg   <= line_len_next;
            field_num_reg  <= field_num_next;
            field_pos_reg  <= field_pos_next;
            in_field_reg   <= in_field_next;
            cand_reg       <= cand_next;
            pseq_reg       <= pseq_next;
            digits_ok_reg  <= digits_ok_next;
            tok_match_reg  <= tok_match_next;
            online_reg     <= online_next;
            wr_en_reg      <= tok_we;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= tok_raddr;
        wr_addr_reg <= tok_waddr;
        wr_data_reg <= c;
        if (accept) begin
            m_data_reg <= {7'd0, ack_next, online_next, cause, seq, ev, status_next};
        end
    end

endmodule
`default_nettype wire

[dv/cls_result_checker.sv]
// Result checker for the command link supervisor: tracks config writes and input beats,
// predicts each result beat, and compares every accepted result field by field.
// Depends on cls_pkg.
module cls_result_checker
    import cls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          results_owed,
    output logic [1:0]  live_status,
    output logic [31:0] live_sequence
);

    localparam logic [7:0] CR = 8'h0D;
    localparam logic [7:0] LF = 8'h0A;

    typedef struct {
        logic [1:0]  status;
        logic [1:0]  send_ev;
        logic [31:0] seq;
        logic [2:0]  cause;
        logic        online;
        logic        ack;
    } link_result_t;

    link_result_t predicted_results[$];

    logic [15:0] cmd_timeout, ack_timeout;
    logic [3:0]  retry_limit;
    status_t     status;
    logic [31:0] next_seq, active_seq;
    logic [3:0]  retry_cnt;
    logic        acked;
    logic [15:0] since_start, since_tx;
    logic [7:0]  expected_tok[TOKEN_MAX_DEF];
    logic [7:0]  pending_tok[TOKEN_MAX_DEF];
    int          expected_len, pending_len;
    logic        pending_comma;
    int          line_len, field_num, field_pos;
    logic        in_field;
    logic [4:0]  candidates;
    logic [31:0] rx_seq;
    logic        rx_seq_ok, tok_ok, online;

    assign live_status   = status;
    assign live_sequence = active_seq;

    function automatic string msg_name(input int i);
        case (i)
            0: return "ACK";
            1: return "STATE";
            2: return "DONE";
            3: return "ERR";
            default: return "FAULT";
        endcase
    endfunction

    function automatic void clear_line();
        line_len = 0; field_num = 0; field_pos = 0; in_field = 1'b0;
        candidates = 5'b11111; rx_seq = '0; rx_seq_ok = 1'b1; tok_ok = 1'b0;
    endfunction

    function automatic void model_reset();
        cmd_timeout = CMD_TIMEOUT_RST; ack_timeout = ACK_TIMEOUT_RST;
        retry_limit = MAX_RETRY_RST;
        status = ST_IDLE; next_seq = 32'd1; active_seq = '0; retry_cnt = '0;
        acked = 1'b0; since_start = '0; since_tx = '0;
        expected_len = 0; pending_len = 0; pending_comma = 1'b0;
        clear_line();
        online = 1'b0;
    endfunction

    function automatic logic [31:0] take_seq();
        logic [31:0] s;
        s = next_seq;
        next_seq = next_seq + 32'd1;
        if (next_seq == 32'd0) next_seq = 32'd1;
        return s;
    endfunction

    function automatic void close_field();
        if (!in_field) return;
        if (field_num == 0) begin
            for (int i = 0; i < NUM_TYPES; i++)
                if (msg_name(i).len() != field_pos) candidates[i] = 1'b0;
        end else if (field_num == 2 && field_pos != expected_len) begin
            tok_ok = 1'b0;
        end
        if (field_num < 3) field_num++;
        in_field = 1'b0;
    endfunction

    function automatic void field_char(input logic [7:0] c);
        string nm;
        logic [35:0] wide;
        if (!in_field) begin
            in_field = 1'b1; field_pos = 0;
            if (field_num == 1) begin rx_seq = '0; rx_seq_ok = 1'b1; end
            if (field_num == 2) tok_ok = 1'b1;
        end
        if (field_num == 0) begin
            for (int i = 0; i < NUM_TYPES; i++) begin
                nm = msg_name(i);
                if (field_pos >= nm.len() || nm[field_pos] != c) candidates[i] = 1'b0;
            end
        end else if (field_num == 1) begin
            if (c >= "0" && c <= "9") begin
                // saturate at all ones instead of wrapping
                wide = {4'd0, rx_seq} * 36'd10 + {28'd0, c - 8'd48};
                rx_seq = (wide > 36'hFFFFFFFF) ? 32'hFFFFFFFF : wide[31:0];
            end else begin
                rx_seq_ok = 1'b0;
            end
        end else if (field_num == 2) begin
            if (field_pos >= expected_len || field_pos >= TOKEN_MAX_DEF
                    || expected_tok[field_pos] != c)
                tok_ok = 1'b0;
        end
        if (field_pos < 255) field_pos++;
    endfunction

    function automatic logic [2:0] end_line();
        logic [2:0] cause;
        logic       for_active, complete;
        cause = CAUSE_NONE;
        close_field();
        online = 1'b1;
        if (field_num >= 2) begin
            for_active = status == ST_RUN && rx_seq_ok && rx_seq == active_seq;
            complete   = field_num >= 3 && tok_ok;
            if ((candidates & 5'b00011) != 0 && for_active) begin
                acked = 1'b1;
            end else if (candidates[2] && for_active && complete) begin
                acked = 1'b1; status = ST_DONE;
            end else if ((candidates & 5'b11000) != 0 && for_active) begin
                acked = 1'b1; status = ST_ERR; cause = CAUSE_SLAVE;
            end
        end
        clear_line();
        return cause;
    endfunction

    function automatic link_result_t supervise_step(input logic [1:0] req,
                                                    input logic [7:0] c, input logic lst);
        link_result_t r;
        r.send_ev = EV_NONE; r.seq = '0; r.cause = CAUSE_NONE;
        case (req)
            REQ_RX: begin
                if (c == CR || c == LF) begin
                    if (line_len != 0) r.cause = end_line();
                end else if (c >= 8'd32 && c <= 8'd126 && line_len < LINE_MAX_DEF) begin
                    line_len++;
                    if (c == ",") close_field();
                    else field_char(c);
                end else if (line_len >= LINE_MAX_DEF) begin
                    clear_line();
                    status = ST_ERR; r.cause = CAUSE_LONG;
                end
            end
            REQ_TICK: begin
                if (status == ST_RUN) begin
                    if (since_start != 16'hFFFF) since_start++;
                    if (since_tx != 16'hFFFF) since_tx++;
                    if (since_start >= cmd_timeout) begin
                        status = ST_ERR; r.cause = CAUSE_CMD_TO;
                        r.send_ev = EV_STOP; r.seq = take_seq();
                    end else if (!acked && since_tx >= ack_timeout) begin
                        if (retry_cnt >= retry_limit) begin
                            status = ST_ERR; r.cause = CAUSE_ACK_TO;
                        end else begin
                            retry_cnt++; since_tx = '0;
                            r.send_ev = EV_RESEND; r.seq = active_seq;
                        end
                    end
                end
            end
            REQ_CMD: begin
                if (c == "," || c == 8'd0) begin
                    pending_comma = 1'b1;
                end else if (!pending_comma && pending_len < TOKEN_MAX_DEF) begin
                    pending_tok[pending_len] = c;
                    pending_len++;
                end
                if (lst) begin
                    if (status == ST_RUN) begin
                        r.cause = CAUSE_BUSY;
                    end else begin
                        status = ST_RUN; since_start = '0; since_tx = '0;
                        active_seq = take_seq();
                        retry_cnt = '0; acked = 1'b0;
                        expected_tok = pending_tok;
                        expected_len = pending_len;
                        r.send_ev = EV_SEND; r.seq = active_seq;
                    end
                    pending_len = 0; pending_comma = 1'b0;
                end
            end
            default: ;
        endcase
        r.status = status;
        r.online = online;
        r.ack = acked;
        return r;
    endfunction

    function automatic void check_field(input string nm, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", nm, want, got);
            fail_count++;
        end
    endfunction

    initial begin
        fail_count = 0;
        results_owed = 0;
        model_reset();
    end

    always @(posedge aclk) begin
        link_result_t want;
        if (!aresetn) begin
            model_reset();
            predicted_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_CMD_TIMEOUT: cmd_timeout = cfg_wdata;
                    REG_ACK_TIMEOUT: ack_timeout = cfg_wdata;
                    REG_MAX_RETRY:   retry_limit = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $error("result beat with nothing predicted: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("task_status", 32'(want.status), 32'(m_tdata[1:0]));
                    check_field("send_event", 32'(want.send_ev), 32'(m_tdata[3:2]));
                    check_field("event_sequence", want.seq, m_tdata[35:4]);
                    check_field("error_cause", 32'(want.cause), 32'(m_tdata[38:36]));
                    check_field("link_online", 32'(want.online), 32'(m_tdata[39]));
                    check_field("ack_seen", 32'(want.ack), 32'(m_tdata[40]));
                end
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(supervise_step(s_tuser, s_tdata, s_tlast));
        end
        results_owed = predicted_results.size();
    end

endmodule

[dv/command_link_supervisor_tb.sv]
// Top of the command link supervisor testbench: clock, reset, stimulus and verdict.
// Depends on cls_pkg, command_link_supervisor and cls_result_checker.
module command_link_supervisor_tb;
    import cls_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int BEATS_PER_PHASE = 240;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    int          fail_count, results_owed;
    logic [1:0]  live_status;
    logic [31:0] live_sequence;

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          beats_sent = 0;
    int          cycles = 0;
    logic [1:0]  seen_status;
    logic [31:0] seen_sequence;
    string       cur_tok = "";

    command_link_supervisor DUT (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_wr_en, .cfg_addr, .cfg_wdata
    );

    cls_result_checker u_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .fail_count, .results_owed, .live_status, .live_sequence
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one beat; returns right after the edge that accepted it
    task automatic push_beat(input req_t r, input logic [7:0] d, input logic l);
        logic rdy;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1; s_tuser <= r; s_tdata <= d; s_tlast <= l;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        beats_sent++;
    endtask

    // drop valid and pause so the predicted state is read after all accepted beats
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        seen_status = live_status;
        seen_sequence = live_sequence;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            push_beat(REQ_RX, txt[i], 1'($urandom_range(1)));
    endtask

    function automatic logic [7:0] rand_tok_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(33, 126)); while (ch == ",");
        return ch;
    endfunction

    task automatic load_command();
        logic [7:0] txt[$];
        string      tok;
        logic       ended;
        int         n;
        n = $urandom_range(1, 17);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) txt.push_back(8'($urandom_range(255)));
            else txt.push_back(rand_tok_char());
        end
        case ($urandom_range(3))
            0: begin txt.push_back(","); txt.push_back(rand_tok_char()); end
            1: txt.push_back(8'd0);
            default: ;
        endcase
        txt.push_back(rand_tok_char());
        tok = ""; ended = 1'b0;
        foreach (txt[i]) begin
            if (txt[i] == "," || txt[i] == 8'd0) ended = 1'b1;
            else if (!ended && tok.len() < TOKEN_MAX_DEF) tok = $sformatf("%s%c", tok, txt[i]);
        end
        for (int i = 0; i < txt.size() - 1; i++) push_beat(REQ_CMD, txt[i], 1'b0);
        settle();
        if (seen_status != ST_RUN) cur_tok = tok;
        push_beat(REQ_CMD, txt[txt.size() - 1], 1'b1);
    endtask

    task automatic send_reply();
        string kind, seqtxt, tok, ln, sep;
        settle();
        case ($urandom_range(9))
            0, 1: kind = "ACK";
            2: kind = "STATE";
            3, 4, 5: kind = "DONE";
            6: kind = "ERR";
            7: kind = "FAULT";
            8: kind = "DON";
            default: kind = "ACKS";
        endcase
        case ($urandom_range(11))
            7: seqtxt = $sformatf("%0d", seen_sequence + 32'd1);
            8: seqtxt = $sformatf("+%0d", seen_sequence);
            9: seqtxt = $sformatf(" %0d", seen_sequence);
            10: seqtxt = ($urandom_range(1) != 0) ? "99999999999" : "4294967296";
            11: seqtxt = "";
            default: seqtxt = $sformatf("%0d", seen_sequence);
        endcase
        case ($urandom_range(9))
            7: tok = {cur_tok, "Z"};
            8: tok = (cur_tok.len() > 1) ? cur_tok.substr(0, cur_tok.len() - 2) : "";
            9: tok = "Q";
            default: tok = cur_tok;
        endcase
        sep = ($urandom_range(4) == 0) ? ",," : ",";
        ln = {kind, sep, seqtxt, ",", tok};
        if ($urandom_range(6) == 0) ln = {ln, ",extra"};
        if ($urandom_range(8) == 0) ln = {",", ln};
        case ($urandom_range(2))
            0: ln = {ln, "\r"};
            1: ln = {ln, "\n"};
            default: ln = {ln, "\r\n"};
        endcase
        send_text(ln);
    endtask

    task automatic random_traffic(input int quota);
        int goal, n;
        goal = beats_sent + quota;
        while (beats_sent < goal) begin
            n = $urandom_range(99);
            if (n < 20) begin
                load_command();
            end else if (n < 55) begin
                send_reply();
            end else if (n < 85) begin
                repeat ($urandom_range(1, 12))
                    push_beat(REQ_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (n < 87) begin
                // overlong line
                repeat ($urandom_range(96, 99))
                    push_beat(REQ_RX, 8'($urandom_range(32, 126)), 1'b0);
                push_beat(REQ_RX, "\n", 1'b0);
            end else begin
                repeat ($urandom_range(1, 4))
                    push_beat(req_t'(2'($urandom_range(3))), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [15:0] cto,
                             input logic [15:0] ato, input logic [3:0] retries);
        wait_drained();
        write_reg(REG_CMD_TIMEOUT, cto);
        write_reg(REG_ACK_TIMEOUT, ato);
        write_reg(REG_MAX_RETRY, {12'd0, retries});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        idle_pct = idle;
        stall_pct = stall;
        random_traffic(BEATS_PER_PHASE);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: start, busy start, ack, done, byte extremes, unknown request, ticks
        push_beat(REQ_CMD, "T", 1'b0);
        push_beat(REQ_CMD, "1", 1'b0);
        push_beat(REQ_CMD, ",", 1'b1);
        cur_tok = "T1";
        push_beat(REQ_CMD, "X", 1'b1);
        send_text("ACK,1\n");
        send_text("DONE,1,T1\r");
        push_beat(REQ_RX, 8'h00, 1'b0);
        push_beat(REQ_RX, 8'hFF, 1'b1);
        push_beat(REQ_NONE, 8'hA5, 1'b0);
        push_beat(REQ_TICK, 8'h5A, 1'b1);
        push_beat(REQ_TICK, 8'h00, 1'b0);

        random_traffic(BEATS_PER_PHASE);
        run_phase(74, 0, 16'd1, 16'd1, 4'd0);
        run_phase(0, 74, 16'd60, 16'd4, 4'd15);
        run_phase(12, 12, 16'd65535, 16'd65535, 4'd2);
        run_phase(0, 0, 16'd25, 16'd3, 4'd1);

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/cls_pkg.sv
hw/rtl/cls_ram.sv
hw/rtl/command_link_supervisor.sv
dv/cls_result_checker.sv
dv/command_link_supervisor_tb.sv
